[rtl/core/msd_pa_pkg.sv]
// Package for the periodic MSD accumulator: field widths, register indexes,
// reset values, state encoding and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msd_pa_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam int BOX_W      = 24;
    localparam int STEP_W     = 16;
    localparam int COUNT_W    = 11;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 64;
    localparam int MSD_W      = 48;
    localparam int SCALE_BITS = 8;
    localparam int DIVIDEND_W = SUM_W + SCALE_BITS;
    localparam int CS_W       = COUNT_W + STEP_W;
    localparam int CSF_W      = CS_W + 3;
    localparam int DEN_W      = CSF_W + TIME_W;

    localparam int DEF_MAX_POLYMERS = 1024;
    localparam int DEF_COORD_BITS   = 24;

    localparam logic [MSD_W-1:0] MSD_MAX = {MSD_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [BOX_W-1:0]   BOX_RESET   = 24'hFFFFFF;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd655;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BOX_X      = 3'd0,
        REG_BOX_Y      = 3'd1,
        REG_BOX_Z      = 3'd2,
        REG_THREE_D    = 3'd3,
        REG_STEP_SIZE  = 3'd4,
        REG_POLY_COUNT = 3'd5,
        REG_START_TIME = 3'd6,
        REG_END_TIME   = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SQUARE,
        ST_ACCUM,
        ST_DEN_A,
        ST_DEN_B,
        ST_DEN_C,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } msd_pa_state_t;

    localparam logic [1:0] AXIS_X       = 2'd0;
    localparam logic [1:0] AXIS_Y       = 2'd1;
    localparam logic [1:0] AXIS_Z       = 2'd2;

endpackage

`default_nettype wire

[rtl/core/msd_pa_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msd_pa_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/msd_pa_div.sv]
// Restoring divider, one quotient bit per cycle: floor(sum * 2^8 / den)
// saturated to 48 bits. Depends on msd_pa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msd_pa_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [msd_pa_pkg::SUM_W-1:0] sum,
    input  wire logic [msd_pa_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic      [msd_pa_pkg::MSD_W-1:0] quotient
);
    import msd_pa_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(DIVIDEND_W - 1);
    localparam logic [CNT_W-1:0] SAT_BIT = CNT_W'(MSD_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      bit_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [MSD_W-1:0]      q_reg;

    logic [DEN_W:0]        trial;
    logic                  ge;
    logic                  sat_hit;
    logic                  den_zero;

    assign trial    = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign sat_hit  = ge && (bit_reg >= SAT_BIT);
    assign den_zero = den == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                bit_reg <= TOP_BIT;
                if (den_zero)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (sat_hit || bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            dvd_reg <= {sum, {SCALE_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
            q_reg   <= den_zero ? MSD_MAX : '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            if (ge)
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
            end
            // A quotient bit at or above bit 48 means the result cannot fit.
            if (sat_hit)
            begin
                q_reg <= MSD_MAX;
            end
            else
            begin
                q_reg <= {q_reg[MSD_W-2:0], ge};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

[rtl/core/msd_periodic_accumulator.sv]
// Top level of the periodic MSD accumulator: request handshakes, config
// registers, position RAM, squaring datapath and normalisation.
// Depends on msd_pa_pkg, msd_pa_ram and msd_pa_div.
//
// Usage: one request per polymer on the input channel (in_valid/in_ready),
// tagged with sim_time; last_polymer marks the end of a frame. A request at
// start_time stores the position in the initial-position RAM (one word of
// three coordinates per polymer). Requests inside the window add the squared
// minimum-image displacement to a 64-bit saturating sum. The last request of a
// frame, if it lies inside the window, produces one result on the output channel.
// Steps: a capture or out-of-window request is handled in the idle state. An
// in-window request steps through a RAM read, a wrap step and a square plus an
// accumulate step per axis on the shared multiplier. A last request that emits
// adds denominator and divider setup (DEN_A, DEN_B, DEN_C, DIV_START), the
// bit-serial divider over the 72-bit scaled dividend (ending early on
// saturation, with no bit steps for a zero denominator) and the load of the
// output register, which waits for the output to be free.
// The output register holds a finished result until out_ready; further
// requests are taken meanwhile, and only the next result waits for it.
// Reset clears the sum, the polymer index and the handshakes and loads the
// register defaults; the position RAM is not cleared and holds garbage
// until the capture frame has written it.
`timescale 1ns / 1ps
`default_nettype none

module msd_periodic_accumulator #(
    parameter int MAX_POLYMERS = msd_pa_pkg::DEF_MAX_POLYMERS,
    parameter int COORD_BITS   = msd_pa_pkg::DEF_COORD_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [msd_pa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [msd_pa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [msd_pa_pkg::TIME_W-1:0]     sim_time,
    input  wire logic [COORD_BITS-1:0]             pos_x,
    input  wire logic [COORD_BITS-1:0]             pos_y,
    input  wire logic [COORD_BITS-1:0]             pos_z,
    input  wire logic                              last_polymer,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [msd_pa_pkg::TIME_W-1:0]     sample_time,
    output logic      [msd_pa_pkg::MSD_W-1:0]      msd_value,
    output logic                                   is_final
);
    import msd_pa_pkg::*;

    localparam int IDX_W  = (MAX_POLYMERS > 1) ? $clog2(MAX_POLYMERS) : 1;
    localparam int WORD_W = 3 * COORD_BITS;
    localparam int MAG_W  = ((COORD_BITS > BOX_W) ? COORD_BITS : BOX_W) + 1;
    localparam int WRK_W  = MAG_W + 2;
    localparam int PROD_W = 2 * MAG_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_POLYMERS - 1);

    // Minimum-image displacement magnitude of one axis.
    function automatic logic [MAG_W-1:0] wrap_mag(
        input logic [COORD_BITS-1:0] pos,
        input logic [COORD_BITS-1:0] init,
        input logic [BOX_W-1:0]      box
    );
        logic signed [WRK_W-1:0] d;
        logic signed [WRK_W-1:0] d2;
        logic signed [WRK_W-1:0] b;
        d  = $signed({{(WRK_W-COORD_BITS){1'b0}}, pos})
           - $signed({{(WRK_W-COORD_BITS){1'b0}}, init});
        b  = $signed({{(WRK_W-BOX_W){1'b0}}, box});
        d2 = d <<< 1;
        if (d2 > b)
        begin
            d = d - b;
        end
        else if (d2 < -b)
        begin
            d = d + b;
        end
        if (d < 0)
        begin
            d = -d;
        end
        return d[MAG_W-1:0];
    endfunction

    // Configuration registers.
    logic [BOX_W-1:0]   box_x_reg;
    logic [BOX_W-1:0]   box_y_reg;
    logic [BOX_W-1:0]   box_z_reg;
    logic               three_d_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  end_reg;

    // Control state.
    msd_pa_state_t      state_reg;
    msd_pa_state_t      state_next;
    logic [IDX_W-1:0]   index_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [1:0]         axis_reg;
    logic               out_valid_reg;

    // Payload registers.
    logic [TIME_W-1:0]     t_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic [COORD_BITS-1:0] pz_reg;
    logic                  last_reg;
    logic [MAG_W-1:0]      mag_x_reg;
    logic [MAG_W-1:0]      mag_y_reg;
    logic [MAG_W-1:0]      mag_z_reg;
    logic [SUM_W-1:0]      sq_reg;
    logic [CS_W-1:0]       cs_reg;
    logic [CSF_W-1:0]      csf_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic [MSD_W-1:0]      out_msd_reg;
    logic                  out_final_reg;

    // Combinational signals.
    logic                  accept;
    logic                  active;
    logic                  capture;
    logic                  in_window;
    logic [WORD_W-1:0]     ram_rdata;
    logic [COORD_BITS-1:0] init_x;
    logic [COORD_BITS-1:0] init_y;
    logic [COORD_BITS-1:0] init_z;
    logic [MAG_W-1:0]      mag_sel;
    logic [PROD_W-1:0]     prod;
    logic [SUM_W+PROD_W-1:0] prod_ext;
    logic [SUM_W:0]        acc_sum;
    logic [1:0]            axis_last;
    logic [TIME_W-1:0]     elapsed;
    logic                  div_start;
    logic                  div_done;
    logic [MSD_W-1:0]      div_q;
    logic                  out_load;
    logic                  out_free;

    assign accept    = in_valid && in_ready;
    assign active    = count_reg != '0;
    assign capture   = active && (sim_time == start_reg);
    assign in_window = active && (sim_time > start_reg) && (sim_time <= end_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign axis_last = three_d_reg ? AXIS_Z : AXIS_Y;
    assign elapsed   = t_reg - start_reg;

    assign init_x = ram_rdata[COORD_BITS-1:0];
    assign init_y = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign init_z = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];

    msd_pa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POLYMERS),
        .ADDR_W(IDX_W)
    ) u_init_ram (
        .clk  (clk),
        .we   (accept && capture),
        .addr (index_reg),
        .wdata({pos_z, pos_y, pos_x}),
        .rdata(ram_rdata)
    );

    msd_pa_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .sum     (sum_reg),
        .den     (den_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    always_comb
    begin
        case (axis_reg)
            AXIS_X:  mag_sel = mag_x_reg;
            AXIS_Y:  mag_sel = mag_y_reg;
            default: mag_sel = mag_z_reg;
        endcase
    end

    assign prod     = mag_sel * mag_sel;
    assign prod_ext = {{SUM_W{1'b0}}, prod};
    assign acc_sum  = {1'b0, sum_reg} + {1'b0, sq_reg};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg   <= BOX_RESET;
            box_y_reg   <= BOX_RESET;
            box_z_reg   <= BOX_RESET;
            three_d_reg <= 1'b1;
            step_reg    <= STEP_RESET;
            count_reg   <= COUNT_RESET;
            start_reg   <= '0;
            end_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BOX_X:      box_x_reg   <= cfg_data[BOX_W-1:0];
                REG_BOX_Y:      box_y_reg   <= cfg_data[BOX_W-1:0];
                REG_BOX_Z:      box_z_reg   <= cfg_data[BOX_W-1:0];
                REG_THREE_D:    three_d_reg <= cfg_data[0];
                REG_STEP_SIZE:  step_reg    <= cfg_data[STEP_W-1:0];
                REG_POLY_COUNT: count_reg   <= cfg_data[COUNT_W-1:0];
                REG_START_TIME: start_reg   <= cfg_data[TIME_W-1:0];
                REG_END_TIME:   end_reg     <= cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and control outputs.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !capture && in_window)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (axis_reg != axis_last)
                begin
                    state_next = ST_SQUARE;
                end
                else if (last_reg)
                begin
                    state_next = ST_DEN_A;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEN_A:
            begin
                state_next = ST_DEN_B;
            end
            ST_DEN_B:
            begin
                state_next = ST_DEN_C;
            end
            ST_DEN_C:
            begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Index, running sum, axis counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            sum_reg       <= '0;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_polymer)
                begin
                    index_reg <= '0;
                end
                else if (index_reg == IDX_LAST)
                begin
                    index_reg <= '0;
                end
                else
                begin
                    index_reg <= index_reg + 1'b1;
                end
                // A last request with no sample clears the sum right away.
                if (last_polymer && (capture || !in_window))
                begin
                    sum_reg <= '0;
                end
            end

            if (state_reg == ST_WRAP)
            begin
                axis_reg <= AXIS_X;
            end
            else if (state_reg == ST_ACCUM)
            begin
                axis_reg <= axis_reg + 1'b1;
                sum_reg  <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
            end

            // The divider has taken its own copy of the sum by now.
            if (div_start)
            begin
                sum_reg <= '0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg    <= sim_time;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
            last_reg <= last_polymer;
        end
        if (state_reg == ST_WRAP)
        begin
            mag_x_reg <= wrap_mag(px_reg, init_x, box_x_reg);
            mag_y_reg <= wrap_mag(py_reg, init_y, box_y_reg);
            mag_z_reg <= wrap_mag(pz_reg, init_z, box_z_reg);
        end
        if (state_reg == ST_SQUARE)
        begin
            sq_reg <= prod_ext[SUM_W-1:0];
        end
        if (state_reg == ST_DEN_A)
        begin
            cs_reg <= CS_W'(count_reg) * CS_W'(step_reg);
        end
        if (state_reg == ST_DEN_B)
        begin
            // Factor 6 is four plus two, factor 4 a plain shift.
            csf_reg <= (CSF_W'(cs_reg) << 2)
                     + (three_d_reg ? (CSF_W'(cs_reg) << 1) : '0);
        end
        if (state_reg == ST_DEN_C)
        begin
            den_reg <= DEN_W'(csf_reg) * DEN_W'(elapsed);
        end
        if (out_load)
        begin
            out_time_reg  <= t_reg;
            out_msd_reg   <= div_q;
            out_final_reg <= t_reg == end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_time = out_time_reg;
    assign msd_value   = out_msd_reg;
    assign is_final    = out_final_reg;

endmodule

`default_nettype wire

[bench/tb_msd_periodic_accumulator.sv]
// Self-checking testbench for msd_periodic_accumulator: drives position requests and
// register writes, predicts every MSD sample and compares it on the output channel.
// Depends on msd_pa_pkg and the msd_periodic_accumulator RTL.
`timescale 1ns / 1ps

module tb_msd_periodic_accumulator;
    import msd_pa_pkg::*;

    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 120;
    localparam int ITEM_TARGET  = 440;
    localparam int QUIET_FROM   = 400;
    localparam int NPOLY        = DEF_MAX_POLYMERS;
    localparam int CW           = DEF_COORD_BITS;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [MSD_W-1:0]  msd;
        logic              fin;
    } sample_t;

    typedef struct {
        logic [BOX_W-1:0]   box_x;
        logic [BOX_W-1:0]   box_y;
        logic [BOX_W-1:0]   box_z;
        logic               three_d;
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  t_start;
        logic [TIME_W-1:0]  t_end;
    } setup_t;

    // Tracks the block's registers, stored positions and running sum, and keeps
    // the samples that are still owed on the output channel.
    class displacement_tracker;
        logic [BOX_W-1:0]   box_x, box_y, box_z;
        logic               three_d;
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  t_start, t_end;
        logic [CW-1:0]      start_pos [3][NPOLY];
        bit                 captured [NPOLY];
        logic [SUM_W-1:0]   sq_sum;
        int unsigned        poly_index;
        sample_t            samples_due [$];
        int                 errors;

        function new();
            box_x = BOX_RESET;
            box_y = BOX_RESET;
            box_z = BOX_RESET;
            three_d = 1'b1;
            step = STEP_RESET;
            count = COUNT_RESET;
            t_start = '0;
            t_end = '0;
            sq_sum = '0;
            poly_index = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BOX_X:      box_x = data[BOX_W-1:0];
                REG_BOX_Y:      box_y = data[BOX_W-1:0];
                REG_BOX_Z:      box_z = data[BOX_W-1:0];
                REG_THREE_D:    three_d = data[0];
                REG_STEP_SIZE:  step = data[STEP_W-1:0];
                REG_POLY_COUNT: count = data[COUNT_W-1:0];
                REG_START_TIME: t_start = data[TIME_W-1:0];
                REG_END_TIME:   t_end = data[TIME_W-1:0];
                default:        ;
            endcase
        endfunction

        function bit window_hit(logic [TIME_W-1:0] t);
            return (count != 0) && (t > t_start) && (t <= t_end);
        endfunction

        // An in-window request reads the stored position of the current slot.
        function bit would_read_blank(logic [TIME_W-1:0] t);
            return window_hit(t) && !captured[poly_index];
        endfunction

        function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            logic [SUM_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        // Minimum-image displacement along one axis, squared.
        function logic [SUM_W-1:0] wrapped_square(logic [CW-1:0] p, logic [CW-1:0] q,
                                                  logic [BOX_W-1:0] box);
            longint d;
            longint b;
            longint mag;
            d = longint'(p) - longint'(q);
            b = longint'(box);
            if (2 * d > b)
                d = d - b;
            else if (2 * d < -b)
                d = d + b;
            mag = (d < 0) ? -d : d;
            return SUM_W'(mag * mag);
        endfunction

        function void take_position(logic [TIME_W-1:0] t, logic [CW-1:0] x, logic [CW-1:0] y,
                                    logic [CW-1:0] z, logic last);
            int unsigned idx;
            bit hit;
            logic [SUM_W-1:0] term;
            logic [TIME_W-1:0] elapsed;
            logic [63:0] den;
            logic [DIVIDEND_W-1:0] quot;
            sample_t due;
            idx = poly_index;
            hit = window_hit(t);
            if (count != 0 && t == t_start)
            begin
                start_pos[0][idx] = x;
                start_pos[1][idx] = y;
                start_pos[2][idx] = z;
                captured[idx] = 1'b1;
            end
            else if (hit)
            begin
                term = wrapped_square(x, start_pos[0][idx], box_x);
                term = sat_add(term, wrapped_square(y, start_pos[1][idx], box_y));
                if (three_d)
                    term = sat_add(term, wrapped_square(z, start_pos[2][idx], box_z));
                sq_sum = sat_add(sq_sum, term);
            end
            if (last)
            begin
                if (hit)
                begin
                    elapsed = t - t_start;
                    den = (three_d ? 64'd6 : 64'd4) * 64'(count) * 64'(step) * 64'(elapsed);
                    if (den == 0)
                        due.msd = MSD_MAX;
                    else
                    begin
                        quot = {sq_sum, {SCALE_BITS{1'b0}}} / DIVIDEND_W'(den);
                        due.msd = (quot > DIVIDEND_W'(MSD_MAX)) ? MSD_MAX : quot[MSD_W-1:0];
                    end
                    due.stamp = t;
                    due.fin = (t == t_end);
                    samples_due.insert(samples_due.size(), due);
                end
                sq_sum = '0;
                poly_index = 0;
            end
            else
                poly_index = (idx + 1) % NPOLY;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_sample(logic [TIME_W-1:0] stamp, logic [MSD_W-1:0] msd, logic fin);
            sample_t due;
            if (samples_due.size() == 0)
            begin
                report($sformatf("unexpected sample, time step %0d", stamp));
                return;
            end
            due = samples_due.pop_front();
            if (stamp !== due.stamp)
                report($sformatf("sample_time %0d, expected %0d", stamp, due.stamp));
            if (msd !== due.msd)
                report($sformatf("msd_value %h, expected %h (step %0d)", msd, due.msd, due.stamp));
            if (fin !== due.fin)
                report($sformatf("is_final %b, expected %b (step %0d)", fin, due.fin, due.stamp));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [TIME_W-1:0]      sim_time = '0;
    logic [CW-1:0]          pos_x = '0;
    logic [CW-1:0]          pos_y = '0;
    logic [CW-1:0]          pos_z = '0;
    logic                   last_polymer = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [TIME_W-1:0]      sample_time;
    logic [MSD_W-1:0]       msd_value;
    logic                   is_final;

    displacement_tracker tracker = new();
    int items_sent = 0;
    bit quiet = 1'b0;
    int stall_left = 0;
    int stuck_cycles = 0;

    msd_periodic_accumulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sim_time     (sim_time),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .last_polymer (last_polymer),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_time  (sample_time),
        .msd_value    (msd_value),
        .is_final     (is_final)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: take samples, with random stall bursts until the quiet tail.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_sample(sample_time, msd_value, is_final);
            if (quiet)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 15);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic hold_off(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_position(logic [TIME_W-1:0] t, logic [CW-1:0] x, logic [CW-1:0] y,
                                 logic [CW-1:0] z, logic last);
        logic [TIME_W-1:0] tt;
        quiet = (items_sent >= QUIET_FROM);
        if (!quiet && $urandom_range(0, 4) == 0)
            hold_off($urandom_range(1, 16));
        // A slot that was never captured must not be read; capture it instead.
        tt = tracker.would_read_blank(t) ? tracker.t_start : t;
        in_valid <= 1'b1;
        sim_time <= tt;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        last_polymer <= last;
        // Hold the request until the block takes it.
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_position(tt, x, y, z, last);
        items_sent++;
    endtask

    task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        tracker.set_reg(idx, data);
        @(posedge clk);
    endtask

    // Registers change only once every owed sample is out and the block has settled.
    task automatic apply_setup(setup_t s);
        in_valid <= 1'b0;
        while (tracker.samples_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        put_reg(REG_BOX_X, CFG_DATA_W'(s.box_x));
        put_reg(REG_BOX_Y, CFG_DATA_W'(s.box_y));
        put_reg(REG_BOX_Z, CFG_DATA_W'(s.box_z));
        put_reg(REG_THREE_D, CFG_DATA_W'(s.three_d));
        put_reg(REG_STEP_SIZE, CFG_DATA_W'(s.step));
        put_reg(REG_POLY_COUNT, CFG_DATA_W'(s.count));
        put_reg(REG_START_TIME, CFG_DATA_W'(s.t_start));
        put_reg(REG_END_TIME, CFG_DATA_W'(s.t_end));
        cfg_write <= 1'b0;
    endtask

    function automatic setup_t make_setup(logic [BOX_W-1:0] bx, by, bz, logic d3,
                                          logic [STEP_W-1:0] st, logic [COUNT_W-1:0] cnt,
                                          logic [TIME_W-1:0] ts, te);
        setup_t s;
        s.box_x = bx;
        s.box_y = by;
        s.box_z = bz;
        s.three_d = d3;
        s.step = st;
        s.count = cnt;
        s.t_start = ts;
        s.t_end = te;
        return s;
    endfunction

    function automatic logic [BOX_W-1:0] pick_box();
        case ($urandom_range(0, 7))
            0:       return 24'd1;
            1:       return 24'hFFFFFF;
            2:       return BOX_W'($urandom_range(1, 255));
            default: return BOX_W'($urandom_range(1, 24'hFFFFFF));
        endcase
    endfunction

    // Often small moves around the captured position, mixed with extreme and fully random coordinates.
    function automatic logic [CW-1:0] pick_coord(int axis);
        int unsigned r;
        logic [CW-1:0] base;
        r = $urandom_range(0, 9);
        base = tracker.start_pos[axis][tracker.poly_index];
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 6 && tracker.captured[tracker.poly_index])
            return base + CW'($urandom_range(0, 8191)) - CW'(4096);
        return CW'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] noise_time();
        case ($urandom_range(0, 4))
            0:       return tracker.t_start;
            1:       return tracker.t_end + 1;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_frame(logic [TIME_W-1:0] t, int n, bit mixed, bit closed);
        logic [TIME_W-1:0] ft;
        for (int i = 0; i < n; i++)
        begin
            ft = (mixed && $urandom_range(0, 2) == 0) ? noise_time() : t;
            send_position(ft, pick_coord(0), pick_coord(1), pick_coord(2),
                          closed && (i == n - 1));
        end
    endtask

    task automatic run_directed();
        // Full, unit and zero box lengths; sample at the last time step.
        apply_setup(make_setup(24'hFFFFFF, 24'd1, 24'd0, 1'b1, 16'd1, 11'd2,
                               32'd10, 32'hFFFFFFFF));
        send_position(32'd10, 24'h000000, 24'h000000, 24'h000000, 1'b0);
        send_position(32'd10, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_position(32'd11, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_position(32'd11, 24'h000000, 24'h000000, 24'h000000, 1'b1);
        send_position(32'd3, 24'h5A5A5A, 24'hA5A5A5, 24'h0F0F0F, 1'b0);
        send_position(32'hFFFFFFFF, 24'h800000, 24'h7FF000, 24'h123456, 1'b1);
        // The last request falls before the window, so this frame gives nothing.
        send_position(32'd12, 24'h400000, 24'h400000, 24'h400000, 1'b0);
        send_position(32'd9, 24'h000000, 24'h000000, 24'h000000, 1'b1);
        // One request where two polymers are configured.
        send_position(32'd12, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b1);

        // 2-D with a zero step size: the sample saturates.
        apply_setup(make_setup(24'h001000, 24'h001000, 24'h001000, 1'b0, 16'd0, 11'd1024,
                               32'hFFFFFFFE, 32'hFFFFFFFF));
        send_position(32'hFFFFFFFE, 24'h001000, 24'h000800, 24'hFFFFFF, 1'b1);
        send_position(32'hFFFFFFFF, 24'h000000, 24'h001800, 24'h000000, 1'b1);
        send_position(32'd0, 24'h000001, 24'h000002, 24'h000003, 1'b1);

        // No polymers configured: everything is ignored.
        apply_setup(make_setup(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'hFFFF, 11'd0,
                               32'd0, 32'd5));
        send_position(32'd0, 24'h111111, 24'h222222, 24'h333333, 1'b0);
        send_position(32'd3, 24'h444444, 24'h555555, 24'h666666, 1'b0);
        send_position(32'd5, 24'h777777, 24'h888888, 24'h999999, 1'b1);

        // End before start: the window is empty.
        apply_setup(make_setup(24'h800000, 24'h800000, 24'h800000, 1'b1, 16'd1, 11'd3,
                               32'd50, 32'd20));
        send_position(32'd50, 24'h000100, 24'h000200, 24'h000300, 1'b1);
        send_position(32'd30, 24'h000400, 24'h000500, 24'h000600, 1'b1);
        send_position(32'd51, 24'h000700, 24'h000800, 24'h000900, 1'b1);

        // Large displacement over one step: the quotient saturates.
        apply_setup(make_setup(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'd1, 11'd1,
                               32'd100, 32'd101));
        send_position(32'd100, 24'h000000, 24'h000000, 24'h000000, 1'b1);
        send_position(32'd101, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    endtask

    task automatic run_random_phase();
        setup_t s;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] t;
        int n;
        int frames;
        s.box_x = pick_box();
        s.box_y = pick_box();
        s.box_z = pick_box();
        s.three_d = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       s.step = 16'd1;
            1:       s.step = 16'hFFFF;
            default: s.step = STEP_W'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 5))
            0:       s.count = 11'd1;
            1:       s.count = 11'd1024;
            default: s.count = COUNT_W'($urandom_range(1, 1024));
        endcase
        case ($urandom_range(0, 5))
            0:       s.t_start = '0;
            1:       s.t_start = 32'hFFFFFFF0;
            default: s.t_start = $urandom;
        endcase
        span = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0)
            s.t_end = s.t_start - (s.t_start != 0);
        else if (s.t_start > 32'hFFFFFFFF - span)
            s.t_end = 32'hFFFFFFFF;
        else
            s.t_end = s.t_start + span;
        span = (s.t_end > s.t_start) ? s.t_end - s.t_start : 1;
        apply_setup(s);

        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        send_frame(s.t_start, n, 1'b0, 1'b1);
        frames = $urandom_range(2, 6);
        for (int f = 0; f < frames; f++)
        begin
            t = (f == frames - 1) ? s.t_end : s.t_start + $urandom_range(1, span);
            case ($urandom_range(0, 9))
                0:       send_frame(noise_time(), $urandom_range(1, 4), 1'b1, 1'b1);
                1:       send_frame(t, $urandom_range(1, n), 1'b0, 1'b0);
                2:       send_frame(t, n, 1'b1, 1'b1);
                3:       send_frame(t, $urandom_range(1, n), 1'b0, 1'b1);
                default: send_frame(t, n, 1'b0, 1'b1);
            endcase
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (items_sent < ITEM_TARGET)
            run_random_phase();
        in_valid <= 1'b0;
        while (tracker.samples_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
